/* src/chb_pkg.sv */
`default_nettype none
package chb_pkg;
    localparam int MaxBuckets = 128;
    localparam int BucketDepth = 8;
    localparam int BktW = $clog2(MaxBuckets);
    localparam int SlotW = $clog2(BucketDepth);
    localparam int FillW = $clog2(BucketDepth + 1);
    localparam int AddrW = BktW + SlotW;
    localparam int KeyW = 31;
    localparam int ValW = 32;
    localparam int CfgW = 8;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DELETED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request, start modulo
        logic div_step;   // one restoring step
        logic fill_rd;    // register fill of bucket
        logic mem_rd;     // read slot at pointer
        logic cmp;        // compare read word, advance pointer
        logic shift_wr;   // write read word one slot down
        logic app_wr;     // append value at fill
        logic fill_wr;    // write new fill, build result
        logic ptr_clr;
        logic found_set;
        status_t status;
    } chb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cmd;
        logic full;
        logic match;
        logic ptr_at_fill;   // pointer reached fill
        logic ptr_last;      // pointer at or past fill-1
    } chb_sts_t;
endpackage
`default_nettype wire

/* src/chained_hash_bucket_store.sv */
`default_nettype none
// Hash table with separate chaining, one request at a time.
// s_axis: tdata = {item_value[31:0], key[30:0]} from bit 0, tuser = command
// (0 insert, 1 delete). m_axis: tdata = {bucket_fill[3:0], bucket_index[6:0],
// status[1:0]} from bit 0, padded to 16 bits.
// cfg: valid/ready/data writes bucket_count (0 acts as 1, above 128 as 128);
// write only while the block is idle.
// Bucket is key modulo bucket_count by a restoring divider, one key bit per
// cycle, then the bucket's fill is read. Insert then appends the value unless
// the bucket is full; delete scans the bucket slot by slot for the value and,
// on a match, shifts the rest of the bucket one slot down. A new request is
// accepted only once the last one has moved into the result register.
// One request is in flight; s_axis_tready is high only while idle. A stalled
// receiver holds the result register; the next request is still accepted but
// its fill and append writes wait until that result has been taken.
// Reset clears the fill counts (by valid bits) and sets bucket_count to 127;
// the entry memory is not cleared, only filled slots are read.
module chained_hash_bucket_store (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // key[30:0], item_value[62:31]
    input  wire logic        s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // status[1:0], bucket_index[8:2], bucket_fill[12:9]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);
    import chb_pkg::*;

    chb_cmd_t         ctl;
    chb_sts_t         sts;
    logic             busy;
    logic             bit_last;
    logic [CfgW-1:0]  bcount_reg;
    logic [1:0]       res_status;
    logic [BktW-1:0]  res_bucket;
    logic [FillW-1:0] res_fill;

    // bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcount_reg <= 8'd127;
        else if (cfg_valid)
            bcount_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    assign s_axis_tready = !busy;

    chb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && !busy),
        .busy(busy), .res_valid(m_axis_tvalid), .res_taken(m_axis_tready),
        .ctl(ctl), .sts(sts), .bit_last(bit_last)
    );

    chb_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
        .req_cmd(s_axis_tuser), .req_key(s_axis_tdata[30:0]),
        .req_val(s_axis_tdata[62:31]), .modulus(bcount_reg), .bit_last(bit_last),
        .res_status(res_status), .res_bucket(res_bucket), .res_fill(res_fill)
    );

    assign m_axis_tdata = {3'b000, res_fill, res_bucket, res_status};

    wire unused_hi = s_axis_tdata[63];
endmodule
`default_nettype wire

/* src/chb_datapath.sv */
`default_nettype none
module chb_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire chb_pkg::chb_cmd_t     ctl,
    output chb_pkg::chb_sts_t          sts,
    input  wire logic                  req_cmd,
    input  wire logic [30:0]           req_key,
    input  wire logic [31:0]           req_val,
    input  wire logic [7:0]            modulus,
    input  wire logic                  bit_last,
    output logic [1:0]                 res_status,
    output logic [chb_pkg::BktW-1:0]   res_bucket,
    output logic [chb_pkg::FillW-1:0]  res_fill
);
    import chb_pkg::*;

    logic                cmd_reg;
    logic [KeyW-1:0]     quo_reg, quo_next;
    logic [CfgW:0]       rem_reg, rem_next;
    logic [CfgW-1:0]     div_reg;
    logic [ValW-1:0]     val_reg;
    logic [FillW-1:0]    fill_reg;
    logic [SlotW:0]      ptr_reg;
    logic [ValW-1:0]     rd_reg;
    logic [BktW-1:0]     bkt;
    logic [FillW-1:0]    fill_new;
    logic [FillW-1:0]    fills [MaxBuckets];
    logic [MaxBuckets-1:0] fvalid_reg;
    logic [ValW-1:0]     mem [MaxBuckets*BucketDepth];
    logic [CfgW:0]       trial;
    logic [CfgW:0]       sub;
    logic [CfgW:0]       unused_rem;

    // restoring modulo step: shift in one key bit
    assign trial = {rem_reg[CfgW-1:0], quo_reg[KeyW-1]};
    assign sub   = trial - {1'b0, div_reg};
    always_comb
    begin
        rem_next = (trial >= {1'b0, div_reg}) ? sub : trial;
        quo_next = {quo_reg[KeyW-2:0], 1'b0};
    end
    assign bkt = rem_reg[BktW-1:0];
    assign unused_rem = rem_reg;

    // request, divider and pointer registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req_cmd;
            val_reg <= req_val;
            quo_reg <= req_key;
            rem_reg <= '0;
            div_reg <= (modulus == 8'd0) ? 8'd1 :
                       (modulus > CfgW'(MaxBuckets)) ? CfgW'(MaxBuckets) : modulus;
        end
        else if (ctl.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctl.fill_rd)
            fill_reg <= fvalid_reg[bkt] ? fills[bkt] : '0;
        if (ctl.ptr_clr)
            ptr_reg <= '0;
        else if (ctl.cmp || ctl.shift_wr)
            ptr_reg <= ptr_reg + 1'b1;
        if (ctl.mem_rd)
            rd_reg <= mem[{bkt, ptr_reg[SlotW-1:0]}];
    end

    // entry memory, one write port
    always_ff @(posedge clk)
    begin
        if (ctl.app_wr)
            mem[{bkt, fill_reg[SlotW-1:0]}] <= val_reg;
        else if (ctl.shift_wr)
            mem[{bkt, ptr_reg[SlotW-1:0] - 1'b1}] <= rd_reg;
    end

    // fill counts with valid bits cleared at reset
    always_comb
    begin
        unique case (ctl.status)
            ST_INSERTED: fill_new = fill_reg + 1'b1;
            ST_DELETED:  fill_new = fill_reg - 1'b1;
            default:     fill_new = fill_reg;
        endcase
    end
    always_ff @(posedge clk)
    begin
        if (ctl.fill_wr)
        begin
            fills[bkt] <= fill_new;
            res_fill   <= fill_new;
            res_status <= ctl.status;
            res_bucket <= bkt;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fvalid_reg <= '0;
        else if (ctl.fill_wr)
            fvalid_reg[bkt] <= 1'b1;
    end

    assign sts.cmd         = cmd_reg;
    assign sts.full        = (fill_reg >= FillW'(BucketDepth));
    assign sts.match       = (rd_reg == val_reg);
    assign sts.ptr_at_fill = ({1'b0, ptr_reg} >= (FillW+1)'(fill_reg));
    assign sts.ptr_last    = ({1'b0, ptr_reg} + 1'b1 >= (FillW+1)'(fill_reg));

    wire unused_ok = bit_last | ctl.found_set | unused_rem[CfgW];

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fill_wr |-> fill_new <= FillW'(BucketDepth))
        else $error("fill above depth");
    a_bkt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fill_wr |-> {1'b0, bkt} < {1'b0, div_reg})
        else $error("bucket beyond modulus");
    a_no_dual: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.app_wr && ctl.shift_wr))
        else $error("two memory writes");
`endif
endmodule
`default_nettype wire

/* src/chb_ctrl.sv */
`default_nettype none
module chb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    output logic                   busy,
    output logic                   res_valid,
    input  wire logic              res_taken,
    output chb_pkg::chb_cmd_t      ctl,
    input  wire chb_pkg::chb_sts_t sts,
    output logic                   bit_last
);
    import chb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_FILL, S_RD, S_CMP, S_SHRD, S_SHWR, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              outv_reg, outv_next;
    logic              res_free;

    assign bit_last = (cnt_reg == 5'd30);
    assign busy = (state_reg != S_IDLE);
    assign res_valid = outv_reg;
    // result register empty, or emptied at this edge
    assign res_free = !outv_reg || res_taken;

    always_comb
    begin
        ctl = '0;
        ctl.status = ST_NOT_FOUND;
        state_next = state_reg;
        cnt_next = cnt_reg;
        outv_next = outv_reg && !res_taken;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ctl.load = 1'b1;
                    cnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (bit_last)
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                ctl.fill_rd = 1'b1;
                ctl.ptr_clr = 1'b1;
                state_next = S_RD;
            end
            S_RD:
            begin
                // insert decides here, delete starts the search
                if (!sts.cmd)
                begin
                    if (res_free)
                    begin
                        ctl.fill_wr = 1'b1;
                        ctl.status = sts.full ? ST_FULL : ST_INSERTED;
                        ctl.app_wr = !sts.full;
                        state_next = S_DONE;
                    end
                end
                else if (sts.ptr_at_fill)
                begin
                    if (res_free)
                    begin
                        ctl.fill_wr = 1'b1;
                        ctl.status = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ctl.mem_rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.cmp = 1'b1;
                if (sts.match)
                    state_next = S_SHRD;
                else
                    state_next = S_RD;
            end
            S_SHRD:
            begin
                // ptr is one past the slot that the shift writes next (the match at first)
                if (sts.ptr_at_fill)
                begin
                    if (res_free)
                    begin
                        ctl.fill_wr = 1'b1;
                        ctl.status = ST_DELETED;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ctl.mem_rd = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                ctl.shift_wr = 1'b1;
                state_next = S_SHRD;
            end
            S_DONE:
            begin
                if (!outv_reg || res_taken)
                begin
                    outv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            outv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            outv_reg <= outv_next;
        end
    end

`ifndef SYNTHESIS
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> $past(state_reg == S_DIV) && $past(cnt_reg) == 5'd30)
        else $error("modulo step count wrong");
    a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fill_wr |=> state_reg == S_DONE)
        else $error("result not held");
    a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fill_wr |-> (!outv_reg || res_taken))
        else $error("result overwritten while pending");
`endif
endmodule
`default_nettype wire

/* bench/tb_chained_hash_bucket_store.sv */
`timescale 1ns / 1ps
module tb_chained_hash_bucket_store;
    import chb_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int DrainCycles = 70;

    typedef struct {
        status_t    status;
        logic [6:0] bucket;
        logic [3:0] fill;
    } bucket_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // key[30:0], item_value[62:31]
    logic        s_axis_tuser = 1'b0; // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // status[1:0], bucket_index[8:2], bucket_fill[12:9]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    // own copy of the table
    logic [31:0] table_words [MaxBuckets][BucketDepth];
    int          table_fill [MaxBuckets];
    logic [7:0]  modulus_reg;

    bucket_result_t pending_results [$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  steady_flow = 1'b0;   // no idling on either side
    int  hold_request = 0;     // receiver hold-off request counter, bumped by the test
    int  hold_seen = 0;
    int  hold_left = 0;
    int  rx_gap = 0;
    logic [31:0] value_pool [8];

    chained_hash_bucket_store DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("tb_chained_hash_bucket_store: done, errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        if (steady_flow)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    // apply one request to the table and work out its result
    function automatic bucket_result_t hash_table_apply(logic cmd, logic [30:0] key,
                                                        logic [31:0] value);
        bucket_result_t r;
        int modulus;
        int bkt;
        int pos;
        modulus = (modulus_reg == 0) ? 1 : (modulus_reg > MaxBuckets ? MaxBuckets : modulus_reg);
        bkt = key % modulus;
        r.bucket = bkt[6:0];
        if (cmd == 1'b0)
        begin
            if (table_fill[bkt] >= BucketDepth)
                r.status = ST_FULL;
            else
            begin
                table_words[bkt][table_fill[bkt]] = value;
                table_fill[bkt]++;
                r.status = ST_INSERTED;
            end
        end
        else
        begin
            pos = 0;
            while (pos < table_fill[bkt] && table_words[bkt][pos] != value)
                pos++;
            if (pos < table_fill[bkt])
            begin
                for (int k = pos; k + 1 < table_fill[bkt]; k++)
                    table_words[bkt][k] = table_words[bkt][k + 1];
                table_fill[bkt]--;
                r.status = ST_DELETED;
            end
            else
                r.status = ST_NOT_FOUND;
        end
        r.fill = table_fill[bkt][3:0];
        return r;
    endfunction

    // send one request and hold it until the transfer
    task automatic send_request(logic cmd, logic [30:0] key, logic [31:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, value, key};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        pending_results.insert(pending_results.size(), hash_table_apply(cmd, key, value));
        begin : gap_after
            int gap;
            gap = idle_length();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_bucket_count(logic [7:0] count);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid   <= 1'b0;
        modulus_reg = count;
    endtask

    // receiver readiness, with its own hold-off counter
    always @(posedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_gap = idle_length();
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin : compare
                bucket_result_t e;
                e = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[8:2] !== e.bucket)
                begin
                    $error("bucket_index: expected %0d, got %0d", e.bucket, m_axis_tdata[8:2]);
                    error_count++;
                end
                if (m_axis_tdata[12:9] !== e.fill)
                begin
                    $error("bucket_fill: expected %0d, got %0d", e.fill, m_axis_tdata[12:9]);
                    error_count++;
                end
                if (m_axis_tdata[15:13] !== 3'b000)
                begin
                    $error("padding: expected 0, got %0d", m_axis_tdata[15:13]);
                    error_count++;
                end
            end
        end
    end

    // default count, key and value extremes
    task automatic test_reset_default();
        send_request(1'b0, 31'd0, 32'h8000_0000);
        send_request(1'b0, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(1'b0, 31'd127, 32'hFFFF_FFFF);
        send_request(1'b1, 31'd254, 32'h1234_5678);   // missing value
        send_request(1'b1, 31'd5, 32'd0);             // empty bucket
        send_request(1'b1, 31'd0, 32'hFFFF_FFFF);
        send_request(1'b1, 31'd127, 32'h8000_0000);
    endtask

    // fill one bucket past full, then delete from the middle and the ends
    task automatic test_bucket_full_and_delete();
        for (int i = 0; i < BucketDepth + 1; i++)
            send_request(1'b0, 31'd3 + 31'd127 * i[30:0], 32'd100 + i);
        send_request(1'b1, 31'd3, 32'd103);
        send_request(1'b1, 31'd3, 32'd100);
        send_request(1'b1, 31'd3, 32'd107);
        send_request(1'b1, 31'd3, 32'd103);
        send_request(1'b0, 31'd3, 32'd103);
    endtask

    // mostly small keys and a small pool of values so deletes hit
    task automatic random_requests(int count);
        logic [30:0] key;
        logic [31:0] value;
        logic        cmd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 99) < 45);
            if ($urandom_range(0, 9) < 7)
                key = 31'($urandom_range(0, 3 * ((modulus_reg == 0) ? 1 : modulus_reg) % 400));
            else
                key = 31'($urandom);
            if ($urandom_range(0, 9) < 6)
                value = value_pool[$urandom_range(0, 7)];
            else
                value = $urandom;
            send_request(cmd, key, value);
        end
    endtask

    // several counts, the extremes among them
    task automatic test_count_settings();
        write_bucket_count(8'd1);
        random_requests(40);
        write_bucket_count(8'd0);
        random_requests(40);
        write_bucket_count(8'd128);
        random_requests(60);
        write_bucket_count(8'd255);
        random_requests(60);
        write_bucket_count(8'd7);
        random_requests(70);
        write_bucket_count(8'd2);
        random_requests(50);
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_backpressure();
        write_bucket_count(8'd13);
        hold_request++;
        random_requests(20);
        wait_drained();
        steady_flow = 1'b1;
        random_requests(40);
        steady_flow = 1'b0;
        write_bucket_count(8'd127);
        random_requests(60);
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        for (int b = 0; b < MaxBuckets; b++)
            table_fill[b] = 0;
        modulus_reg = 8'd127;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default();
        test_bucket_full_and_delete();
        test_count_settings();
        test_backpressure();

        wait_drained();
        if (error_count == 0)
            $display("tb_chained_hash_bucket_store: done, clean");
        else
            $display("tb_chained_hash_bucket_store: done, errors");
        $finish;
    end
endmodule

/* filelist.f */
src/chb_pkg.sv
src/chb_datapath.sv
src/chb_ctrl.sv
src/chained_hash_bucket_store.sv
bench/tb_chained_hash_bucket_store.sv
